### rtl/body_motion_integrator_core_assert.svh
// Assertion macros shared by the integrator RTL.
`ifndef BODY_MOTION_INTEGRATOR_CORE_ASSERT_SVH
`define BODY_MOTION_INTEGRATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BMI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/bmi_pkg.sv
package bmi_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned CHUNK_BITS   = 16;

  localparam logic KIND_STEP   = 1'b0;
  localparam logic KIND_RELOAD = 1'b1;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BODY_MASS,
    REG_TIME_STEP,
    REG_INIT_X,
    REG_INIT_Y,
    REG_INIT_Z,
    REG_INIT_VX,
    REG_INIT_VY,
    REG_INIT_VZ
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_AT,
    OP_VT,
    OP_HALF,
    OP_SQ
  } mul_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIV_W,
    S_MUL,
    S_MUL_W,
    S_ADD,
    S_POS,
    S_SQRT,
    S_SQRT_W,
    S_OUT
  } state_e;

endpackage

### rtl/bmi_if.sv
interface bmi_in_if #(parameter int unsigned WORD_BITS = 48);
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [WORD_BITS-1:0] force_x;
  logic signed [WORD_BITS-1:0] force_y;
  logic signed [WORD_BITS-1:0] force_z;

  modport source (output valid, kind, force_x, force_y, force_z, input ready);
  modport sink (input valid, kind, force_x, force_y, force_z, output ready);
endinterface

interface bmi_out_if #(parameter int unsigned WORD_BITS = 48);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] pos_x;
  logic signed [WORD_BITS-1:0] pos_y;
  logic signed [WORD_BITS-1:0] pos_z;
  logic signed [WORD_BITS-1:0] vel_x;
  logic signed [WORD_BITS-1:0] vel_y;
  logic signed [WORD_BITS-1:0] vel_z;
  logic signed [WORD_BITS-1:0] acc_x;
  logic signed [WORD_BITS-1:0] acc_y;
  logic signed [WORD_BITS-1:0] acc_z;
  logic        [WORD_BITS-1:0] step_length;
  logic                        saturated;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  acc_x, acc_y, acc_z, step_length, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                acc_x, acc_y, acc_z, step_length, saturated, output ready);
endinterface

### rtl/bmi_div.sv
// Restoring divider, one quotient bit per cycle.
module bmi_div #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned NW = WORD_BITS + FRAC_BITS,
  localparam int unsigned CW = $clog2(NW + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NW-1:0]        num_i,
  input  logic [WORD_BITS-1:0] den_i,
  output logic                 busy_o,
  output logic [NW-1:0]        quot_o
);

  logic [CW-1:0]        cnt_q;
  logic [NW-1:0]        num_q;
  logic [WORD_BITS-1:0] rem_q;
  logic [WORD_BITS-1:0] den_q;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS+1:0] diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = !diff[WORD_BITS+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q;

endmodule

### rtl/bmi_mul.sv
// Sequential multiplier: one operand chunk per cycle, most significant first.
module bmi_mul #(
  parameter int unsigned A_BITS = 48,
  parameter int unsigned B_BITS = 48,
  localparam int unsigned C   = bmi_pkg::CHUNK_BITS,
  localparam int unsigned NCH = (B_BITS + C - 1) / C,
  localparam int unsigned BP  = NCH * C,
  localparam int unsigned CW  = $clog2(NCH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [A_BITS-1:0]        a_i,
  input  logic [B_BITS-1:0]        b_i,
  output logic                     busy_o,
  output logic [A_BITS+B_BITS-1:0] prod_o
);

  logic [CW-1:0]        cnt_q;
  logic [A_BITS-1:0]    a_q;
  logic [BP-1:0]        b_q;
  logic [A_BITS+BP-1:0] acc_q;
  logic [A_BITS+C-1:0]  pp;

  assign pp = a_q * b_q[BP-1 -: C];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NCH);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BP'(b_i);
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q << C) + (A_BITS + BP)'(pp);
      b_q   <= b_q << C;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q[A_BITS+B_BITS-1:0];

endmodule

### rtl/bmi_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module bmi_sqrt #(
  parameter int unsigned WORD_BITS = 48,
  localparam int unsigned CW = $clog2(WORD_BITS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2*WORD_BITS-1:0] rad_i,
  output logic                   busy_o,
  output logic [WORD_BITS-1:0]   root_o
);

  logic [CW-1:0]          cnt_q;
  logic [2*WORD_BITS-1:0] rad_q;
  logic [WORD_BITS+1:0]   rem_q;
  logic [WORD_BITS-1:0]   root_q;
  logic [WORD_BITS+3:0]   rem_sh;
  logic [WORD_BITS+3:0]   trial;
  logic [WORD_BITS+4:0]   diff;
  logic                   ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[2*WORD_BITS-1 -: 2]};
    trial  = (WORD_BITS + 4)'({root_q, 2'b01});
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    ge     = !diff[WORD_BITS+4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(WORD_BITS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[WORD_BITS+1:0] : rem_sh[WORD_BITS+1:0];
      root_q <= {root_q[WORD_BITS-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule

### rtl/body_motion_integrator_core.sv
// Constant-acceleration motion step of one body.
// item_i carries kind and a force vector; result_o returns the new position,
// velocity and acceleration, the length of the step's displacement and a flag
// that is set when any value was clamped to its range. Each accepted item
// gives exactly one result. Registers are to be written on the cfg port while
// idle; the block itself does not enforce this. A step runs the three axes
// one after the other through one divider (one quotient bit a cycle), one
// multiplier (16 multiplier bits a cycle, four products per axis) and finally
// a square-root unit (one root bit a cycle). item_i.ready is high only while
// the block is idle, so the block takes no new item until the receiver has
// taken the result of the last one. A finished result holds on result_o until
// the receiver takes it; a stall there simply holds the block in that state.
// Reset clears position, velocity, acceleration and step length, sets the
// mass and time step to one, and clears the initial-state registers.
`include "body_motion_integrator_core_assert.svh"

module body_motion_integrator_core #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned CFG_DATA_BITS =
    (WORD_BITS > bmi_pkg::TIME_BITS) ? WORD_BITS : bmi_pkg::TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bmi_in_if.sink                          item_i,
  bmi_out_if.source                       result_o,
  input  logic                            cfg_we_i,
  input  logic [bmi_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data_i
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned BW = CFG_DATA_BITS;
  localparam int unsigned PW = W + BW;
  localparam int unsigned NW = W + F;
  localparam int unsigned TB = bmi_pkg::TIME_BITS;

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } smag_t;

  typedef struct packed {
    smag_t v;
    logic  clip;
  } sat_t;

  function automatic sat_t sat_f(input logic neg, input logic [PW-1:0] mag);
    sat_t         r;
    logic [PW-1:0] lim;
    lim      = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    r.clip   = (mag > lim);
    r.v.mag  = r.clip ? lim[W-1:0] : mag[W-1:0];
    r.v.neg  = neg && (r.v.mag != '0);
    return r;
  endfunction

  function automatic sat_t add_f(input smag_t a, input smag_t b);
    logic [PW-1:0] ea;
    logic [PW-1:0] eb;
    ea = PW'(a.mag);
    eb = PW'(b.mag);
    if (a.neg == b.neg) begin
      return sat_f(a.neg, ea + eb);
    end else if (a.mag >= b.mag) begin
      return sat_f(a.neg, ea - eb);
    end else begin
      return sat_f(b.neg, eb - ea);
    end
  endfunction

  function automatic smag_t decode_f(input logic [W-1:0] x);
    smag_t s;
    s.neg = x[W-1];
    s.mag = s.neg ? (W'(0) - x) : x;
    return s;
  endfunction

  function automatic logic [W-1:0] encode_f(input smag_t s);
    return s.neg ? (W'(0) - s.mag) : s.mag;
  endfunction

  // Configuration registers.
  logic [W-1:0]  mass_q;
  logic [TB-1:0] tstep_q;
  logic [W-1:0]  ipos_q[3];
  logic [W-1:0]  ivel_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q  <= W'(1) << F;
      tstep_q <= TB'(1) << F;
      for (int i = 0; i < 3; i++) begin
        ipos_q[i] <= '0;
        ivel_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (bmi_pkg::cfg_reg_e'(cfg_idx_i))
        bmi_pkg::REG_BODY_MASS: mass_q    <= cfg_data_i[W-1:0];
        bmi_pkg::REG_TIME_STEP: tstep_q   <= cfg_data_i[TB-1:0];
        bmi_pkg::REG_INIT_X:    ipos_q[0] <= cfg_data_i[W-1:0];
        bmi_pkg::REG_INIT_Y:    ipos_q[1] <= cfg_data_i[W-1:0];
        bmi_pkg::REG_INIT_Z:    ipos_q[2] <= cfg_data_i[W-1:0];
        bmi_pkg::REG_INIT_VX:   ivel_q[0] <= cfg_data_i[W-1:0];
        bmi_pkg::REG_INIT_VY:   ivel_q[1] <= cfg_data_i[W-1:0];
        bmi_pkg::REG_INIT_VZ:   ivel_q[2] <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and body state.
  bmi_pkg::state_e  state_q, state_d;
  bmi_pkg::mul_op_e op_q;
  logic [1:0]       axis_q;
  logic             flag_q;
  logic [W-1:0]     pos_q[3];
  logic [W-1:0]     vel_q[3];
  logic [W-1:0]     acc_q[3];
  logic [W-1:0]     len_q;

  // Per-axis working values.
  logic [W-1:0]   force_q[3];
  smag_t          a_q, at_q, vt_q, half_q, d_q;
  logic [2*W-1:0] sumsq_q;

  logic item_xfer;
  logic div_start, mul_start, sqrt_start;
  logic div_busy, mul_busy, sqrt_busy;

  logic [NW-1:0]   div_quot;
  logic [NW-1:0]   quot_fix;
  logic [W-1:0]    mul_a;
  logic [BW-1:0]   mul_b;
  logic [PW-1:0]   mul_prod;
  logic [W-1:0]    sqrt_root;

  smag_t cur_f, cur_v, cur_p;
  sat_t  a_res, at_res, vt_res, half_res, d_res, vel_res, pos_res;

  assign item_xfer = item_i.valid && item_i.ready;

  always_comb begin
    cur_f    = decode_f(force_q[axis_q]);
    cur_v    = decode_f(vel_q[axis_q]);
    cur_p    = decode_f(pos_q[axis_q]);
    // A zero mass makes the divider return all ones, which then clamps.
    quot_fix = (cur_f.mag == '0) ? '0 : div_quot;
    a_res    = sat_f(cur_f.neg, PW'(quot_fix));
    at_res   = sat_f(a_q.neg, mul_prod >> F);
    vt_res   = sat_f(cur_v.neg, mul_prod >> F);
    half_res = sat_f(at_q.neg, mul_prod >> (F + 1));
    d_res    = add_f(vt_q, half_q);
    vel_res  = add_f(cur_v, at_q);
    pos_res  = add_f(cur_p, d_q);
  end

  always_comb begin
    case (op_q)
      bmi_pkg::OP_AT:   mul_a = a_q.mag;
      bmi_pkg::OP_VT:   mul_a = cur_v.mag;
      bmi_pkg::OP_HALF: mul_a = at_q.mag;
      bmi_pkg::OP_SQ:   mul_a = d_q.mag;
      default:          mul_a = d_q.mag;
    endcase
    mul_b = (op_q == bmi_pkg::OP_SQ) ? BW'(d_q.mag) : BW'(tstep_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state_q)
      bmi_pkg::S_IDLE: begin
        if (item_i.valid) begin
          state_d = (item_i.kind == bmi_pkg::KIND_RELOAD) ? bmi_pkg::S_OUT : bmi_pkg::S_DIV;
        end
      end
      bmi_pkg::S_DIV: begin
        div_start = 1'b1;
        state_d   = bmi_pkg::S_DIV_W;
      end
      bmi_pkg::S_DIV_W: begin
        if (!div_busy) begin
          state_d = bmi_pkg::S_MUL;
        end
      end
      bmi_pkg::S_MUL: begin
        mul_start = 1'b1;
        state_d   = bmi_pkg::S_MUL_W;
      end
      bmi_pkg::S_MUL_W: begin
        if (!mul_busy) begin
          case (op_q)
            bmi_pkg::OP_HALF: state_d = bmi_pkg::S_ADD;
            bmi_pkg::OP_SQ: begin
              state_d = (axis_q == bmi_pkg::LAST_AXIS) ? bmi_pkg::S_SQRT : bmi_pkg::S_DIV;
            end
            default: state_d = bmi_pkg::S_MUL;
          endcase
        end
      end
      bmi_pkg::S_ADD:  state_d = bmi_pkg::S_POS;
      bmi_pkg::S_POS:  state_d = bmi_pkg::S_MUL;
      bmi_pkg::S_SQRT: begin
        sqrt_start = 1'b1;
        state_d    = bmi_pkg::S_SQRT_W;
      end
      bmi_pkg::S_SQRT_W: begin
        if (!sqrt_busy) begin
          state_d = bmi_pkg::S_OUT;
        end
      end
      bmi_pkg::S_OUT: begin
        if (result_o.ready) begin
          state_d = bmi_pkg::S_IDLE;
        end
      end
      default: state_d = bmi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= bmi_pkg::OP_AT;
      axis_q <= '0;
      flag_q <= 1'b0;
      len_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      case (state_q)
        bmi_pkg::S_IDLE: begin
          if (item_xfer) begin
            flag_q <= 1'b0;
            axis_q <= '0;
            op_q   <= bmi_pkg::OP_AT;
            if (item_i.kind == bmi_pkg::KIND_RELOAD) begin
              len_q <= '0;
              for (int i = 0; i < 3; i++) begin
                pos_q[i] <= ipos_q[i];
                vel_q[i] <= ivel_q[i];
                acc_q[i] <= '0;
              end
            end
          end
        end
        bmi_pkg::S_DIV_W: begin
          if (!div_busy) begin
            flag_q         <= flag_q | a_res.clip;
            acc_q[axis_q]  <= encode_f(a_res.v);
            op_q           <= bmi_pkg::OP_AT;
          end
        end
        bmi_pkg::S_MUL_W: begin
          if (!mul_busy) begin
            case (op_q)
              bmi_pkg::OP_AT: begin
                flag_q <= flag_q | at_res.clip;
                op_q   <= bmi_pkg::OP_VT;
              end
              bmi_pkg::OP_VT: begin
                flag_q <= flag_q | vt_res.clip;
                op_q   <= bmi_pkg::OP_HALF;
              end
              bmi_pkg::OP_HALF: flag_q <= flag_q | half_res.clip;
              default: begin
                if (axis_q != bmi_pkg::LAST_AXIS) begin
                  axis_q <= axis_q + 2'd1;
                end
              end
            endcase
          end
        end
        bmi_pkg::S_ADD: begin
          flag_q        <= flag_q | d_res.clip | vel_res.clip;
          vel_q[axis_q] <= encode_f(vel_res.v);
        end
        bmi_pkg::S_POS: begin
          flag_q        <= flag_q | pos_res.clip;
          pos_q[axis_q] <= encode_f(pos_res.v);
          op_q          <= bmi_pkg::OP_SQ;
        end
        bmi_pkg::S_SQRT_W: begin
          if (!sqrt_busy) begin
            len_q <= sqrt_root;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bmi_pkg::S_IDLE && item_xfer) begin
      force_q[0] <= item_i.force_x;
      force_q[1] <= item_i.force_y;
      force_q[2] <= item_i.force_z;
      sumsq_q    <= '0;
    end
    if (state_q == bmi_pkg::S_DIV_W && !div_busy) begin
      a_q <= a_res.v;
    end
    if (state_q == bmi_pkg::S_MUL_W && !mul_busy) begin
      case (op_q)
        bmi_pkg::OP_AT:   at_q   <= at_res.v;
        bmi_pkg::OP_VT:   vt_q   <= vt_res.v;
        bmi_pkg::OP_HALF: half_q <= half_res.v;
        default:          sumsq_q <= sumsq_q + mul_prod[2*W-1:0];
      endcase
    end
    if (state_q == bmi_pkg::S_ADD) begin
      d_q <= d_res.v;
    end
  end

  bmi_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({cur_f.mag, {F{1'b0}}}),
    .den_i   (mass_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  bmi_mul #(.A_BITS(W), .B_BITS(BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  bmi_sqrt #(.WORD_BITS(W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sumsq_q),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  assign item_i.ready = (state_q == bmi_pkg::S_IDLE);

  assign result_o.valid       = (state_q == bmi_pkg::S_OUT);
  assign result_o.pos_x       = pos_q[0];
  assign result_o.pos_y       = pos_q[1];
  assign result_o.pos_z       = pos_q[2];
  assign result_o.vel_x       = vel_q[0];
  assign result_o.vel_y       = vel_q[1];
  assign result_o.vel_z       = vel_q[2];
  assign result_o.acc_x       = acc_q[0];
  assign result_o.acc_y       = acc_q[1];
  assign result_o.acc_z       = acc_q[2];
  assign result_o.step_length = len_q;
  assign result_o.saturated   = flag_q;

  `BMI_ASSERT_IMP(a_out_blocks_in, clk_i, rst_ni, result_o.valid, !item_i.ready)
  `BMI_ASSERT_NEXT(a_xfer_leaves_idle, clk_i, rst_ni, item_xfer, !item_i.ready)
  `BMI_ASSERT_IMP(a_div_in_wait, clk_i, rst_ni, div_busy, state_q == bmi_pkg::S_DIV_W)
  `BMI_ASSERT_NEXT(a_result_to_idle, clk_i, rst_ni, result_o.valid && result_o.ready, item_i.ready)

endmodule

### tb/body_motion_integrator_core_tb.sv
module body_motion_integrator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WB = 48;
  localparam int unsigned FB = 16;
  localparam logic [WB-1:0] WMASK = {WB{1'b1}};
  localparam logic [WB-1:0] SMAX = {1'b0, {(WB-1){1'b1}}};
  localparam int unsigned CYCLE_LIMIT = 8000000;

  typedef struct packed {
    logic          kind;
    logic [WB-1:0] fx, fy, fz;
  } motion_cmd_t;

  typedef struct packed {
    logic [WB-1:0] px, py, pz, vx, vy, vz, ax, ay, az, len;
    logic          sat;
  } motion_state_t;

  typedef struct {
    logic          neg;
    logic [WB-1:0] mag;
  } smag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bmi_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [WB-1:0] cfg_data_i = '0;

  bmi_in_if #(.WORD_BITS(WB)) item_bus ();
  bmi_out_if #(.WORD_BITS(WB)) result_bus ();

  body_motion_integrator_core #(.WORD_BITS(WB), .FRAC_BITS(FB)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_i(item_bus.sink), .result_o(result_bus.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and register shadow.
  logic [WB-1:0] pos_q [3];
  logic [WB-1:0] vel_q [3];
  logic [WB-1:0] acc_q [3];
  logic [WB-1:0] len_q;
  logic [WB-1:0] mass_q, ix_q [3], iv_q [3];
  logic [31:0]   dt_q;

  motion_cmd_t   cmd_queue [$];
  motion_state_t motion_expected [$];
  int unsigned   errors = 0;
  int unsigned   accepted = 0;
  int unsigned   cycles = 0;
  int            send_gap = 0;
  int            take_gap = 0;

  function automatic smag_t clamp_mag(input logic neg, input logic [127:0] m, inout logic flag);
    smag_t r;
    logic [127:0] lim;
    lim = neg ? {80'b0, SMAX} + 128'd1 : {80'b0, SMAX};
    if (m > lim) begin
      m = lim;
      flag = 1'b1;
    end
    r.mag = m[WB-1:0];
    r.neg = neg && (m != 0);
    return r;
  endfunction

  function automatic smag_t signed_add(input smag_t a, input smag_t b, inout logic flag);
    if (a.neg == b.neg) return clamp_mag(a.neg, {80'b0, a.mag} + {80'b0, b.mag}, flag);
    if (a.mag >= b.mag) return clamp_mag(a.neg, {80'b0, a.mag - b.mag}, flag);
    return clamp_mag(b.neg, {80'b0, b.mag - a.mag}, flag);
  endfunction

  function automatic smag_t split_sign(input logic [WB-1:0] v);
    smag_t s;
    s.neg = v[WB-1];
    s.mag = s.neg ? -v : v;
    return s;
  endfunction

  function automatic logic [WB-1:0] join_sign(input smag_t s);
    return s.neg ? -s.mag : s.mag;
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] res, one, t;
    res = 0;
    one = 128'd1 << 126;
    while (one > n) one = one >> 2;
    while (one != 0) begin
      t = res + one;
      if (n >= t) begin
        n = n - t;
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic motion_state_t advance_body(input motion_cmd_t c);
    motion_state_t r;
    logic flag;
    logic [127:0] sumsq, root;
    logic [WB-1:0] frc [3];
    smag_t f, a, at, vt, half, d, v;
    flag = 1'b0;
    sumsq = 0;
    frc[0] = c.fx; frc[1] = c.fy; frc[2] = c.fz;
    if (c.kind == bmi_pkg::KIND_RELOAD) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] = ix_q[i];
        vel_q[i] = iv_q[i];
        acc_q[i] = '0;
      end
      len_q = '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        f = split_sign(frc[i]);
        v = split_sign(vel_q[i]);
        if (mass_q == 0) a = (f.mag != 0) ? clamp_mag(f.neg, {80'b0, WMASK}, flag) : f;
        else a = clamp_mag(f.neg, ({80'b0, f.mag} << FB) / {80'b0, mass_q}, flag);
        at = clamp_mag(a.neg, ({80'b0, a.mag} * {96'b0, dt_q}) >> FB, flag);
        vt = clamp_mag(v.neg, ({80'b0, v.mag} * {96'b0, dt_q}) >> FB, flag);
        half = clamp_mag(at.neg, ({80'b0, at.mag} * {96'b0, dt_q}) >> (FB + 1), flag);
        d = signed_add(vt, half, flag);
        pos_q[i] = join_sign(signed_add(split_sign(pos_q[i]), d, flag));
        vel_q[i] = join_sign(signed_add(v, at, flag));
        acc_q[i] = join_sign(a);
        sumsq = sumsq + {80'b0, d.mag} * {80'b0, d.mag};
      end
      root = floor_sqrt(sumsq);
      if (root > {80'b0, WMASK}) begin
        root = {80'b0, WMASK};
        flag = 1'b1;
      end
      len_q = root[WB-1:0];
    end
    r.px = pos_q[0]; r.py = pos_q[1]; r.pz = pos_q[2];
    r.vx = vel_q[0]; r.vy = vel_q[1]; r.vz = vel_q[2];
    r.ax = acc_q[0]; r.ay = acc_q[1]; r.az = acc_q[2];
    r.len = len_q;
    r.sat = flag;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 400);
    return $urandom_range(0, 4);
  endfunction

  // Driver: one transfer at a time from the command queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_bus.valid && item_bus.ready) begin
        motion_expected.push_back(advance_body('{item_bus.kind, item_bus.force_x,
                                                 item_bus.force_y, item_bus.force_z}));
        accepted <= accepted + 1;
        void'(cmd_queue.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        item_bus.valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        item_bus.valid <= 1'b1;
        item_bus.kind <= cmd_queue[0].kind;
        item_bus.force_x <= cmd_queue[0].fx;
        item_bus.force_y <= cmd_queue[0].fy;
        item_bus.force_z <= cmd_queue[0].fz;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor with random receiver stalls.
  always @(posedge clk_i) begin
    motion_state_t got, want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        got = '{result_bus.pos_x, result_bus.pos_y, result_bus.pos_z,
                result_bus.vel_x, result_bus.vel_y, result_bus.vel_z,
                result_bus.acc_x, result_bus.acc_y, result_bus.acc_z,
                result_bus.step_length, result_bus.saturated};
        if (motion_expected.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = motion_expected.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors <= errors + 1;
          end
        end
        take_gap = pick_gap();
      end
      if (take_gap > 0) begin
        take_gap = take_gap - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input bmi_pkg::cfg_reg_e idx, input logic [WB-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bmi_pkg::REG_BODY_MASS: mass_q = val;
      bmi_pkg::REG_TIME_STEP: dt_q = val[31:0];
      bmi_pkg::REG_INIT_X:    ix_q[0] = val;
      bmi_pkg::REG_INIT_Y:    ix_q[1] = val;
      bmi_pkg::REG_INIT_Z:    ix_q[2] = val;
      bmi_pkg::REG_INIT_VX:   iv_q[0] = val;
      bmi_pkg::REG_INIT_VY:   iv_q[1] = val;
      bmi_pkg::REG_INIT_VZ:   iv_q[2] = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained(input int unsigned target);
    while (accepted < target || motion_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [WB-1:0] rand_word();
    logic [WB-1:0] w;
    w = WB'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: return w;
      1: return {{(WB-40){w[39]}}, w[39:0]};
      2: return {{(WB-28){w[27]}}, w[27:0]};
      3: return {{(WB-20){w[19]}}, w[19:0]};
      4: return {1'b1, {(WB-1){1'b0}}};
      default: return {{(WB-24){w[23]}}, w[23:0]};
    endcase
  endfunction

  function automatic motion_cmd_t make_step(input logic [WB-1:0] f);
    return '{bmi_pkg::KIND_STEP, f, -f, rand_word()};
  endfunction

  int unsigned queued = 0;

  task automatic push_cmd(input motion_cmd_t c);
    cmd_queue.push_back(c);
    queued++;
  endtask

  initial begin
    logic [WB-1:0] masses [5];
    logic [31:0]   steps [5];
    item_bus.valid = 1'b0;
    item_bus.kind = 1'b0;
    item_bus.force_x = '0;
    item_bus.force_y = '0;
    item_bus.force_z = '0;
    result_bus.ready = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pos_q[i] = '0; vel_q[i] = '0; acc_q[i] = '0; ix_q[i] = '0; iv_q[i] = '0;
    end
    len_q = '0;
    mass_q = 48'd65536;
    dt_q = 32'd65536;
    masses = '{48'd1, 48'd65536, WMASK, 48'd0, 48'd300000};
    steps = '{32'd1, 32'd65536, 32'hFFFF_FFFF, 32'd4096, 32'd200000};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: defaults, extremes of forces, reloads.
    push_cmd('{bmi_pkg::KIND_STEP, '0, '0, '0});
    push_cmd('{bmi_pkg::KIND_STEP, SMAX, {1'b1, {(WB-1){1'b0}}}, 48'd1});
    push_cmd('{bmi_pkg::KIND_STEP, WMASK, 48'd65536, -48'd65536});
    push_cmd('{bmi_pkg::KIND_RELOAD, WMASK, WMASK, WMASK});
    push_cmd('{bmi_pkg::KIND_STEP, 48'd123456, -48'd7, SMAX});
    wait_drained(queued);

    write_reg(bmi_pkg::REG_INIT_X, SMAX);
    write_reg(bmi_pkg::REG_INIT_Y, {1'b1, {(WB-1){1'b0}}});
    write_reg(bmi_pkg::REG_INIT_Z, 48'd1000);
    write_reg(bmi_pkg::REG_INIT_VX, SMAX);
    write_reg(bmi_pkg::REG_INIT_VY, {1'b1, {(WB-1){1'b0}}});
    write_reg(bmi_pkg::REG_INIT_VZ, -48'd65536);
    write_reg(bmi_pkg::REG_BODY_MASS, 48'd0);
    write_reg(bmi_pkg::REG_TIME_STEP, {16'b0, 32'hFFFF_FFFF});
    push_cmd('{bmi_pkg::KIND_RELOAD, '0, '0, '0});
    push_cmd('{bmi_pkg::KIND_STEP, SMAX, '0, {1'b1, {(WB-1){1'b0}}}});
    push_cmd('{bmi_pkg::KIND_STEP, '0, '0, '0});
    push_cmd('{bmi_pkg::KIND_RELOAD, '0, '0, '0});
    wait_drained(queued);

    // Random phases across settings.
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(bmi_pkg::REG_BODY_MASS, (ph < 5) ? masses[ph] :
                ($urandom_range(0, 1) ? {16'b0, $urandom} : rand_word()));
      write_reg(bmi_pkg::REG_TIME_STEP,
                {16'b0, ((ph < 5) ? steps[ph] : 32'($urandom_range(1, 300000)))});
      write_reg(bmi_pkg::REG_INIT_X, rand_word());
      write_reg(bmi_pkg::REG_INIT_Y, rand_word());
      write_reg(bmi_pkg::REG_INIT_Z, rand_word());
      write_reg(bmi_pkg::REG_INIT_VX, rand_word());
      write_reg(bmi_pkg::REG_INIT_VY, rand_word());
      write_reg(bmi_pkg::REG_INIT_VZ, rand_word());
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) == 0) push_cmd('{bmi_pkg::KIND_RELOAD, rand_word(), '0, '0});
        else push_cmd(make_step(rand_word()));
      end
      wait_drained(queued);
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
